/* rtl/tar_pkg.sv */
// Shared types and constants for the telecontrol APDU receiver.
package tar_pkg;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] LEN_BYTE   = 8'h04;
  localparam logic [7:0] S_CTRL     = 8'h01;
  localparam logic [7:0] U_STARTCON = 8'h0B;
  localparam logic [7:0] U_STOPCON  = 8'h23;
  localparam logic [7:0] U_TESTCON  = 8'h83;
  localparam logic [7:0] TY_SP      = 8'h01;
  localparam logic [7:0] TY_ME_NA   = 8'h09;
  localparam logic [7:0] TY_SC      = 8'h2D;
  localparam logic [7:0] TY_DC      = 8'h2E;
  localparam logic [7:0] TY_IC      = 8'h64;
  localparam logic [7:0] TY_CS      = 8'h67;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0][7:0]  args;
    logic [7:0]       otype;
    logic [15:0]      ca;
    logic [23:0]      ioa;
    logic [23:0]      val;
    logic [5:0]       count;
    logic             xfer;
    logic             ovf;
  } cmd_t;

endpackage

/* rtl/tar_front.sv */
// Front end: frame parser, object store and command stage.
module tar_front import tar_pkg::*; #(
  parameter int unsigned StoreDepth = 32,
  parameter int unsigned MaxLen     = 253
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] rx_byte_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  localparam int unsigned IW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned FW = $clog2(StoreDepth + 1);

  typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_BODY} phase_e;

  phase_e       phase_q, phase_d;
  logic [14:0]  seq_q, seq_d;
  logic [7:0]   idx_q, idx_d, len_q, len_d, fc_q, fc_d, asdu_q, asdu_d;
  logic [6:0]   ann_q, ann_d, seen_q, seen_d;
  logic [15:0]  st_q, st_d;
  logic [47:0]  asm_q, asm_d;
  logic [2:0]   pos_q, pos_d, size;
  logic [FW-1:0] fill_q, fill_d;
  logic         xfer_q, xfer_d, ovf_q, ovf_d;
  logic         s1_v_q;
  cmd_t         s1_q, s1_d;
  logic         emit, we, rd, acc, adv;
  logic [23:0]  mem_ts [StoreDepth];
  logic [47:0]  mem_av [StoreDepth];
  logic [23:0]  rd_ts;
  logic [47:0]  rd_av;
  logic [23:0]  w_ts;
  logic [47:0]  w_av;

  assign adv        = !s1_v_q || cmd_ready_i;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;

  always_comb begin
    phase_d = phase_q; seq_d = seq_q; idx_d = idx_q; len_d = len_q;
    fc_d = fc_q; asdu_d = asdu_q; ann_d = ann_q; st_d = st_q;
    asm_d = asm_q; seen_d = seen_q; pos_d = pos_q; fill_d = fill_q;
    xfer_d = xfer_q; ovf_d = ovf_q;
    emit = 1'b0; we = 1'b0; rd = 1'b0; size = 3'd0;
    s1_d = '0;
    w_ts = '0; w_av = '0;
    if (acc) begin
      if (operation_i) begin
        emit = 1'b1;
        if (fill_q != '0) begin
          s1_d.kind = KIND_POP;
          fill_d    = fill_q - 1'b1;
          rd        = 1'b1;
        end else begin
          s1_d.kind = KIND_EMPTY;
        end
      end else begin
        unique case (phase_q)
          PH_HUNT: if (rx_byte_i == START_BYTE) phase_d = PH_LEN;
          PH_LEN: begin
            if (rx_byte_i == 8'd0 || rx_byte_i > 8'(MaxLen)) begin
              phase_d = PH_HUNT;
            end else begin
              phase_d = PH_BODY; len_d = rx_byte_i; idx_d = '0; fc_d = '0;
              asdu_d = '0; ann_d = '0; st_d = '0; seen_d = '0; pos_d = '0;
            end
          end
          PH_BODY: begin
            if (idx_q == 8'd0) fc_d = rx_byte_i;
            if (idx_q == 8'd4) asdu_d = rx_byte_i;
            if (idx_q == 8'd5) ann_d = rx_byte_i[6:0];
            if (idx_q == 8'd8) st_d[7:0] = rx_byte_i;
            if (idx_q == 8'd9) st_d[15:8] = rx_byte_i;
            if (asdu_d == TY_SP || asdu_d == TY_SC || asdu_d == TY_DC) size = 3'd4;
            else if (asdu_d == TY_ME_NA) size = 3'd6;
            if (idx_q >= 8'd10 && !fc_d[0] && size != 3'd0 && seen_q < ann_d) begin
              asm_d[{pos_q, 3'b000} +: 8] = rx_byte_i;
              pos_d = pos_q + 1'b1;
              if (pos_q == size - 3'd1) begin
                pos_d  = '0;
                seen_d = seen_q + 1'b1;
                w_ts   = {st_d, asdu_d};
                w_av   = {(size == 3'd6) ? asm_d[47:24] : {16'd0, asm_d[31:24]},
                          asm_d[23:0]};
                if (fill_q < FW'(StoreDepth)) begin
                  we     = 1'b1;
                  fill_d = fill_q + 1'b1;
                end else begin
                  ovf_d = 1'b1;
                end
              end
            end
            idx_d = idx_q + 1'b1;
            if (idx_d >= len_q) begin
              phase_d = PH_HUNT;
              if (len_q >= 8'd4) begin
                if (!fc_d[0]) begin
                  seq_d = seq_q + 1'b1;
                  if (asdu_d != TY_IC && asdu_d != TY_CS) begin
                    emit = 1'b1;
                    s1_d.args = {seq_d[14:7], {seq_d[6:0], 1'b0}, 8'd0, S_CTRL};
                  end
                end else if (fc_d[1]) begin
                  if (fc_d[2]) begin
                    xfer_d = 1'b1; emit = 1'b1;
                    s1_d.args = {24'd0, U_STARTCON};
                  end else if (fc_d[4]) begin
                    xfer_d = 1'b0; emit = 1'b1;
                    s1_d.args = {24'd0, U_STOPCON};
                  end else if (fc_d[6]) begin
                    emit = 1'b1;
                    s1_d.args = {24'd0, U_TESTCON};
                  end
                end
              end
            end
          end
          default: phase_d = PH_HUNT;
        endcase
      end
    end
    s1_d.count = 6'(fill_d);
    s1_d.xfer  = xfer_d;
    s1_d.ovf   = ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_ts[fill_q[IW-1:0]] <= w_ts;
      mem_av[fill_q[IW-1:0]] <= w_av;
    end
    if (rd) begin
      rd_ts <= mem_ts[fill_d[IW-1:0]];
      rd_av <= mem_av[fill_d[IW-1:0]];
    end
    if (adv) s1_q <= s1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT; seq_q <= '0; idx_q <= '0; len_q <= '0; fc_q <= '0;
      asdu_q <= '0; ann_q <= '0; st_q <= '0; asm_q <= '0; seen_q <= '0;
      pos_q <= '0; fill_q <= '0; xfer_q <= 1'b0; ovf_q <= 1'b0; s1_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d; seq_q <= seq_d; idx_q <= idx_d; len_q <= len_d;
      fc_q <= fc_d; asdu_q <= asdu_d; ann_q <= ann_d; st_q <= st_d;
      asm_q <= asm_d; seen_q <= seen_d; pos_q <= pos_d; fill_q <= fill_d;
      xfer_q <= xfer_d; ovf_q <= ovf_d;
      if (adv) s1_v_q <= emit;
    end
  end

  always_comb begin
    cmd_o = s1_q;
    if (s1_q.kind == KIND_POP) begin
      cmd_o.otype = rd_ts[7:0];
      cmd_o.ca    = rd_ts[23:8];
      cmd_o.ioa   = rd_av[23:0];
      cmd_o.val   = rd_av[47:24];
    end
  end
  assign cmd_valid_o = s1_v_q;

endmodule

/* rtl/tar_queue.sv */
// Command queue between parser front end and transmit back end.
module tar_queue import tar_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          wr, rd;

  assign wr_ready_o = cnt_q != (PW + 1)'(QUEUE_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW + 1)'(wr) - (PW + 1)'(rd);
    end
  end

endmodule

/* rtl/tar_back.sv */
// Back end: turns queued commands into result transfers.
module tar_back import tar_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [7:0]  object_type_o,
  output logic [15:0] common_address_o,
  output logic [23:0] object_address_o,
  output logic [23:0] object_value_o,
  output logic        last_o,
  output logic [5:0]  stored_count_o,
  output logic        transfer_enabled_o,
  output logic        overflow_o
);

  logic [2:0] cnt_q;
  logic       is_tx, xfer;

  assign is_tx = cmd_i.kind == KIND_TX;
  assign out_valid_o = cmd_valid_i;
  assign xfer = out_valid_o && out_ready_i;
  assign last_o = !is_tx || cnt_q == 3'd5;
  assign cmd_ready_o = xfer && last_o;

  always_comb begin
    case (cnt_q)
      3'd0:    tx_byte_o = START_BYTE;
      3'd1:    tx_byte_o = LEN_BYTE;
      3'd2:    tx_byte_o = cmd_i.args[0];
      3'd3:    tx_byte_o = cmd_i.args[1];
      3'd4:    tx_byte_o = cmd_i.args[2];
      default: tx_byte_o = cmd_i.args[3];
    endcase
    if (!is_tx) tx_byte_o = 8'd0;
  end

  assign kind_o             = cmd_i.kind;
  assign object_type_o      = cmd_i.otype;
  assign common_address_o   = cmd_i.ca;
  assign object_address_o   = cmd_i.ioa;
  assign object_value_o     = cmd_i.val;
  assign stored_count_o     = cmd_i.count;
  assign transfer_enabled_o = cmd_i.xfer;
  assign overflow_o         = cmd_i.ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (xfer) begin
      cnt_q <= last_o ? 3'd0 : cnt_q + 1'b1;
    end
  end

endmodule

/* rtl/telecontrol_apdu_receiver.sv */
// Top level of the telecontrol APDU receiver.
// One input item accepted per cycle unless a command held in the command stage
// stalls the input; results pass the command stage, then the queue. An ack or
// U-reply is 6 output transfers, a pop 1; a 4-entry queue decouples input from
// output stalls. Asynchronous active-low reset clears parser, flags and fill
// count; store contents are not cleared.
module telecontrol_apdu_receiver import tar_pkg::*; #(
  parameter int unsigned STORE_DEPTH      = 32,
  parameter int unsigned MAX_FRAME_LENGTH = 253
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [7:0]  object_type_o,
  output logic [15:0] common_address_o,
  output logic [23:0] object_address_o,
  output logic [23:0] object_value_o,
  output logic        last_o,
  output logic [5:0]  stored_count_o,
  output logic        transfer_enabled_o,
  output logic        overflow_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  tar_front #(.StoreDepth(STORE_DEPTH), .MaxLen(MAX_FRAME_LENGTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .rx_byte_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  tar_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_cmd)
  );

  tar_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .out_valid_o, .out_ready_i, .kind_o, .tx_byte_o, .object_type_o,
    .common_address_o, .object_address_o, .object_value_o, .last_o,
    .stored_count_o, .transfer_enabled_o, .overflow_o
  );

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o != 2'd3) else $error("bad result kind");

  a_reply_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && kind_o == KIND_TX)
    else $error("reply broken off");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_EMPTY |-> stored_count_o == 6'd0)
    else $error("empty pop with objects held");

endmodule

/* tb/tb.sv */
// Testbench for the telecontrol APDU receiver: frame parsing, object store and replies.
`timescale 1ns / 100ps

module tb;
  import tar_pkg::*;

  localparam int STORE_MAX = 32;
  localparam int MAX_LEN   = 253;
  localparam int WATCHDOG  = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [7:0]  otype;
    logic [15:0] ca;
    logic [23:0] ioa;
    logic [23:0] val;
    logic        last;
    logic [5:0]  count;
    logic        xfer;
    logic        ovf;
  } reply_t;

  typedef enum logic [1:0] {HUNT, LENGTH, BODY} phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        operation_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic [7:0]  object_type_o;
  logic [15:0] common_address_o;
  logic [23:0] object_address_o;
  logic [23:0] object_value_o;
  logic        last_o;
  logic [5:0]  stored_count_o;
  logic        transfer_enabled_o;
  logic        overflow_o;

  telecontrol_apdu_receiver dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [14:0] rx_seq;
  phase_e      phase;
  logic [7:0]  idx, flen, ctrl, asdu_ty;
  logic [6:0]  announced, seen;
  logic [15:0] station;
  logic [47:0] assembly;
  logic [23:0] st_ts [STORE_MAX];
  logic [47:0] st_av [STORE_MAX];
  int          fill;
  logic        xfer_flag, ovf_flag;

  reply_t replies_due[$];
  int     send_idle_pct, recv_idle_pct;
  int     errors, idle_cycles;
  reply_t step_out[$];

  task automatic put_tx(input logic [7:0] b);
    reply_t r;
    r = '0;
    r.kind = KIND_TX;
    r.tx = b;
    step_out.push_back(r);
  endtask

  task automatic put_short(input logic [7:0] b2, b3, b4, b5);
    put_tx(START_BYTE);
    put_tx(LEN_BYTE);
    put_tx(b2);
    put_tx(b3);
    put_tx(b4);
    put_tx(b5);
  endtask

  task automatic close_frame();
    if (flen < 4) return;
    if (!ctrl[0]) begin
      rx_seq = rx_seq + 15'd1;
      if (asdu_ty != TY_IC && asdu_ty != TY_CS)
        put_short(S_CTRL, 8'h00, {rx_seq[6:0], 1'b0}, rx_seq[14:7]);
    end else if (ctrl[1]) begin
      if (ctrl[2]) begin
        xfer_flag = 1'b1;
        put_short(U_STARTCON, 8'h00, 8'h00, 8'h00);
      end else if (ctrl[4]) begin
        xfer_flag = 1'b0;
        put_short(U_STOPCON, 8'h00, 8'h00, 8'h00);
      end else if (ctrl[6]) begin
        put_short(U_TESTCON, 8'h00, 8'h00, 8'h00);
      end
    end
  endtask

  task automatic predict_step(input logic op, input logic [7:0] b);
    int size, pos;
    reply_t r;
    step_out.delete();
    if (op) begin
      r = '0;
      if (fill > 0) begin
        fill--;
        r.kind = KIND_POP;
        r.otype = st_ts[fill][7:0];
        r.ca = st_ts[fill][23:8];
        r.ioa = st_av[fill][23:0];
        r.val = st_av[fill][47:24];
      end else begin
        r.kind = KIND_EMPTY;
      end
      step_out.push_back(r);
    end else if (phase == HUNT) begin
      if (b == START_BYTE) phase = LENGTH;
    end else if (phase == LENGTH) begin
      if (b == 0 || b > MAX_LEN) phase = HUNT;
      else begin
        phase = BODY;
        flen = b;
        idx = 0; ctrl = 0; asdu_ty = 0; announced = 0; station = 0;
        assembly = 0; seen = 0;
      end
    end else begin
      case (idx)
        8'd0: ctrl = b;
        8'd4: asdu_ty = b;
        8'd5: announced = b[6:0];
        8'd8: station[7:0] = b;
        8'd9: station[15:8] = b;
        default: ;
      endcase
      size = 0;
      if (asdu_ty == TY_SP || asdu_ty == TY_SC || asdu_ty == TY_DC) size = 4;
      else if (asdu_ty == TY_ME_NA) size = 6;
      if (idx >= 10 && !ctrl[0] && size != 0 && seen < announced) begin
        pos = (int'(idx) - 10) % size;
        if (pos == 0) assembly = 0;
        assembly[8*pos +: 8] = b;
        if (pos == size - 1) begin
          if (fill < STORE_MAX) begin
            st_ts[fill] = {station, asdu_ty};
            st_av[fill] = (size == 6) ? assembly : {16'd0, assembly[31:0]};
            fill++;
          end else ovf_flag = 1'b1;
          seen++;
        end
      end
      idx = idx + 8'd1;
      if (idx >= flen) begin
        phase = HUNT;
        close_frame();
      end
    end
    foreach (step_out[k]) begin
      r = step_out[k];
      r.last = (k == step_out.size() - 1);
      r.count = fill[5:0];
      r.xfer = xfer_flag;
      r.ovf = ovf_flag;
      replies_due.push_back(r);
    end
  endtask

  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_step(op, b);
  endtask

  task automatic send_frame(input logic [7:0] body[$]);
    send_item(1'b0, START_BYTE);
    send_item(1'b0, 8'(body.size()));
    foreach (body[k]) send_item(1'b0, body[k]);
  endtask

  function automatic void i_frame(ref logic [7:0] f[$], input logic [7:0] ty,
                                  input int n, input logic [15:0] ca);
    int sz;
    sz = (ty == TY_ME_NA) ? 6 : 4;
    f = {8'h00, 8'h00, 8'h00, 8'h00, ty, n[7:0], 8'h03, 8'h00, ca[7:0], ca[15:8]};
    for (int k = 0; k < n * sz; k++) f.push_back(8'($urandom_range(255)));
  endfunction

  always @(posedge clk_i) begin
    reply_t got, want;
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {kind_o, tx_byte_o, object_type_o, common_address_o, object_address_o,
             object_value_o, last_o, stored_count_o, transfer_enabled_o, overflow_o};
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: %p", got);
      end else begin
        want = replies_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    logic [7:0] f[$];
    send_item(1'b1, 8'h00);                          // empty pop
    send_item(1'b0, 8'hFF);                          // noise
    send_item(1'b0, START_BYTE); send_item(1'b0, 8'd254); // oversized
    send_item(1'b0, START_BYTE); send_item(1'b0, 8'd0);   // empty
    f = {8'h07, 8'h00};
    send_frame(f);                                   // short frame
    f = {8'h07, 8'h00, 8'h00, 8'h00};
    send_frame(f);                                   // STARTDT
    f = {8'h43, 8'h00, 8'h00, 8'h00};
    send_frame(f);                                   // TESTFR
    f = {8'h13, 8'h00, 8'h00, 8'h00};
    send_frame(f);                                   // STOPDT
    f = {8'h03, 8'h00, 8'h00, 8'h00};
    send_frame(f);                                   // U with no bits
    f = {8'h01, 8'h00, 8'h00, 8'h00};
    send_frame(f);                                   // S-frame
    f = {8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(f);                                   // missing ASDU
    f = {8'h00, 8'h00, 8'h00, 8'h00, TY_IC};
    send_frame(f);
    f = {8'h00, 8'h00, 8'h00, 8'h00, TY_CS};
    send_frame(f);
    f = {8'h00, 8'h00, 8'h00, 8'h00, 8'h65};
    send_frame(f);
    i_frame(f, TY_ME_NA, 1, 16'hFFFF);
    f.push_back(8'hAA);                              // trailing byte past the announced object
    send_frame(f);
    send_item(1'b1, 8'hFF);
  endtask

  task automatic test_store_overflow();
    logic [7:0] f[$];
    i_frame(f, TY_SC, 33, 16'h1234);
    f[5] = 8'hA1;                                    // SQ bit set, ignored
    send_frame(f);
    send_item(1'b1, 8'h5A);
  endtask

  task automatic test_random(input int n);
    logic [7:0] f[$];
    int sel;
    for (int k = 0; k < n; ) begin
      sel = $urandom_range(9);
      if (sel < 5) begin
        case ($urandom_range(3))
          0: i_frame(f, TY_SP, $urandom_range(3), 16'($urandom_range(65535)));
          1: i_frame(f, TY_ME_NA, $urandom_range(2), 16'($urandom_range(65535)));
          2: i_frame(f, TY_DC, $urandom_range(3), 16'($urandom_range(65535)));
          default: f = {8'($urandom_range(255) | 1), 8'h00, 8'h00, 8'h00};
        endcase
        if ($urandom_range(4) == 0 && f.size() > 1) void'(f.pop_back());
        send_frame(f);
        k += f.size() + 2;
      end else if (sel < 7) begin
        send_item(1'b1, 8'($urandom_range(255)));
        k++;
      end else begin
        send_item(1'b0, 8'($urandom_range(255)));
        k++;
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    rx_seq = 0; phase = HUNT; idx = 0; flen = 0; ctrl = 0; asdu_ty = 0;
    announced = 0; seen = 0; station = 0; assembly = 0; fill = 0;
    xfer_flag = 0; ovf_flag = 0; errors = 0; idle_cycles = 0;
    send_idle_pct = 17; recv_idle_pct = 77;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 77; recv_idle_pct = 17;
    test_store_overflow();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(12);
    drain();
    if (errors == 0 && replies_due.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
